// ===== hdl/ksel_pkg.sv =====
// Shared types and constants for the k-smallest index selector.
package ksel_pkg;

  localparam int VALUE_W = 64;
  localparam int INDEX_W = 16;
  localparam int WANT_W  = 5;
  localparam logic [WANT_W-1:0] WANT_RESET = 5'd8;

  localparam int               MAX_KEPT_DEF  = 16;
  localparam longint unsigned  MAX_ITEMS_DEF = 64'd65536;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } ksel_state_t;

  typedef struct packed {
    logic load;   // take the offered word into the row
    logic shift;  // move the row one place towards the head
    logic clear;  // end of run
  } ksel_cmd_t;

  typedef struct packed {
    logic last_word;  // one kept entry left
  } ksel_sts_t;

endpackage

// ===== hdl/ksel_ctrl.sv =====
// Controller: collects words until the final one, then drains the kept indices.
module ksel_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               final_item,
  output logic               sample_stall,
  output logic               rank_valid,
  input  logic               rank_stall,
  output ksel_pkg::ksel_cmd_t cmd,
  input  ksel_pkg::ksel_sts_t sts
);
  import ksel_pkg::*;

  ksel_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    rank_valid   = 1'b0;
    cmd          = '0;
    case (state)
      ST_COLLECT: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          cmd.load = 1'b1;
          if (final_item) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        rank_valid = 1'b1;
        if (!rank_stall) begin
          cmd.shift = 1'b1;
          if (sts.last_word) begin
            cmd.clear  = 1'b1;
            state_next = ST_COLLECT;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

endmodule

// ===== hdl/ksel_dpath.sv =====
// Datapath: sorted row of compare-and-shift cells, index counter, run flags.
module ksel_dpath #(
  parameter int              MAX_KEPT  = ksel_pkg::MAX_KEPT_DEF,
  parameter longint unsigned MAX_ITEMS = ksel_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               count_wanted_we,
  input  logic [ksel_pkg::WANT_W-1:0]        count_wanted,
  input  logic signed [ksel_pkg::VALUE_W-1:0] sample_value,
  input  ksel_pkg::ksel_cmd_t                cmd,
  output ksel_pkg::ksel_sts_t                sts,
  output logic [ksel_pkg::INDEX_W-1:0]       rank_index,
  output logic                               run_end,
  output logic                               index_overflow
);
  import ksel_pkg::*;

  localparam int KW    = $clog2(MAX_KEPT + 1);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [KW-1:0]    K_MAX   = KW'(MAX_KEPT);

  logic [WANT_W-1:0]         want;
  logic [KW-1:0]             k_eff;
  logic [KW-1:0]             fill, fill_eff, fill_next;
  logic [CNT_W-1:0]          item_count;
  logic                      overflow;
  logic                      sat, full;
  logic [INDEX_W-1:0]        new_index;

  logic signed [VALUE_W-1:0] kval [MAX_KEPT];
  logic [INDEX_W-1:0]        kidx [MAX_KEPT];
  logic [MAX_KEPT-1:0]       take;

  always_ff @(posedge clk) begin
    if (rst) begin
      want <= WANT_RESET;
    end else if (count_wanted_we) begin
      want <= count_wanted;
    end
  end

  always_comb begin
    if (want == '0) begin
      k_eff = KW'(1);
    end else if (int'(want) > MAX_KEPT) begin
      k_eff = K_MAX;
    end else begin
      k_eff = KW'(want);
    end
    fill_eff  = (fill > k_eff) ? k_eff : fill;
    full      = (fill_eff == k_eff);
    fill_next = full ? fill_eff : fill_eff + KW'(1);
    sat       = (item_count == CNT_MAX);
    new_index = sat ? INDEX_W'(CNT_MAX - CNT_W'(1)) : INDEX_W'(item_count);
  end

  // Cell j takes a new entry when its value is above the key, or when it
  // is the first free slot of a list that is not yet full.
  for (genvar j = 0; j < MAX_KEPT; j++) begin : g_cell
    localparam logic [KW-1:0] J = KW'(j);
    assign take[j] = ((J < fill_eff) && (kval[j] > sample_value)) ||
                     ((J == fill_eff) && !full);

    always_ff @(posedge clk) begin
      if (cmd.load && take[j]) begin
        if (j > 0 && take[(j > 0) ? j - 1 : 0]) begin
          kval[j] <= kval[(j > 0) ? j - 1 : 0];
          kidx[j] <= kidx[(j > 0) ? j - 1 : 0];
        end else begin
          kval[j] <= sample_value;
          kidx[j] <= new_index;
        end
      end else if (cmd.shift && j < MAX_KEPT - 1) begin
        kval[j] <= kval[(j < MAX_KEPT - 1) ? j + 1 : j];
        kidx[j] <= kidx[(j < MAX_KEPT - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill       <= '0;
      item_count <= '0;
      overflow   <= 1'b0;
    end else if (cmd.load) begin
      fill <= fill_next;
      if (sat) begin
        overflow <= 1'b1;
      end else begin
        item_count <= item_count + CNT_W'(1);
      end
    end else if (cmd.shift) begin
      fill <= fill - KW'(1);
    end
  end

  assign sts.last_word   = (fill == KW'(1));
  assign rank_index      = kidx[0];
  assign run_end         = sts.last_word;
  assign index_overflow  = overflow;

endmodule

// ===== hdl/k_smallest_index_selector.sv =====
// Top level of the k-smallest index selector.
//
//  channel   direction  handshake                     payload
//  sample    in         sample_valid / sample_stall   sample_value, final_item
//  rank      out        rank_valid / rank_stall       rank_index, run_end, index_overflow
//  config    in         count_wanted_we               count_wanted
//
// One sample word per cycle while collecting; every kept entry is compared in
// parallel by its own cell, so each word is inserted into the row as it is accepted.
// After the final word, one rank word per cycle for each kept entry (1 to K) while rank_stall is low,
// with sample_stall high throughout the drain.
// rank_stall holds the head of the row and its flags in place.
// Synchronous reset empties the row, clears the counter and sets K to 8.
module k_smallest_index_selector #(
  parameter int              MAX_KEPT  = ksel_pkg::MAX_KEPT_DEF,
  parameter longint unsigned MAX_ITEMS = ksel_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                count_wanted_we,
  input  logic [ksel_pkg::WANT_W-1:0]         count_wanted,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [ksel_pkg::VALUE_W-1:0] sample_value,
  input  logic                                final_item,
  output logic                                rank_valid,
  input  logic                                rank_stall,
  output logic [ksel_pkg::INDEX_W-1:0]        rank_index,
  output logic                                run_end,
  output logic                                index_overflow
);
  import ksel_pkg::*;

  ksel_cmd_t cmd;
  ksel_sts_t sts;

  ksel_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .final_item   (final_item),
    .sample_stall (sample_stall),
    .rank_valid   (rank_valid),
    .rank_stall   (rank_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  ksel_dpath #(
    .MAX_KEPT  (MAX_KEPT),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .count_wanted_we (count_wanted_we),
    .count_wanted    (count_wanted),
    .sample_value    (sample_value),
    .cmd             (cmd),
    .sts             (sts),
    .rank_index      (rank_index),
    .run_end         (run_end),
    .index_overflow  (index_overflow)
  );

endmodule

// ===== hdl/ksel_chk.sv =====
// Port-level checks for the k-smallest index selector, bound to the top level.
module ksel_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_stall,
  input logic                          final_item,
  input logic                          rank_valid,
  input logic                          rank_stall,
  input logic [ksel_pkg::INDEX_W-1:0]  rank_index,
  input logic                          run_end
);
  import ksel_pkg::*;

  // No sample taken while a rank word is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rank_valid |-> sample_stall)
    else $error("sample accepted during drain");

  // A final word starts the drain on the next cycle.
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && final_item) |=> rank_valid)
    else $error("no drain after final word");

  // The drain stops right after the word flagged as run end.
  a_drain_stop: assert property (@(posedge clk) disable iff (rst)
    (rank_valid && !rank_stall && run_end) |=> !rank_valid)
    else $error("rank word after run end");

  // A stalled rank word holds.
  a_rank_hold: assert property (@(posedge clk) disable iff (rst)
    (rank_valid && rank_stall) |=> (rank_valid && $stable(rank_index) && $stable(run_end)))
    else $error("stalled rank word changed");

endmodule

bind k_smallest_index_selector ksel_chk u_ksel_chk (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .final_item   (final_item),
  .rank_valid   (rank_valid),
  .rank_stall   (rank_stall),
  .rank_index   (rank_index),
  .run_end      (run_end)
);
